@@ rtl/gdsu_pkg.sv @@
// ----------------------------------------------------------------------------
// gdsu_pkg
// shared types, constants and calendar functions for the gregorian date
// step unit
// ----------------------------------------------------------------------------
`default_nettype none

package gdsu_pkg;

    localparam int DAY_W     = 5;
    localparam int MON_W     = 4;
    localparam int YEAR_IN_W = 14;
    localparam int YEAR_W    = 16;   // internal year, holds any year limit
    localparam int COUNT_W   = 16;
    localparam int ORDER_W   = 2;

    localparam int MAX_STEPS_DEF = 65535;
    localparam int YEAR_MAX_DEF  = 9999;

    localparam logic [MON_W-1:0]   MON_JAN  = 4'd1;
    localparam logic [MON_W-1:0]   MON_FEB  = 4'd2;
    localparam logic [MON_W-1:0]   MON_APR  = 4'd4;
    localparam logic [MON_W-1:0]   MON_JUN  = 4'd6;
    localparam logic [MON_W-1:0]   MON_SEP  = 4'd9;
    localparam logic [MON_W-1:0]   MON_NOV  = 4'd11;
    localparam logic [MON_W-1:0]   MON_DEC  = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
    localparam logic [DAY_W-1:0]   DAY_31   = 5'd31;
    localparam logic [DAY_W-1:0]   DAY_30   = 5'd30;
    localparam logic [DAY_W-1:0]   DAY_29   = 5'd29;
    localparam logic [DAY_W-1:0]   DAY_28   = 5'd28;
    localparam logic [COUNT_W-1:0] DIST_SAT = 16'hFFFF;

    // divisibility by 25 through the modular inverse of 25 mod 2^16
    localparam logic [YEAR_W-1:0] INV25     = 16'd23593;
    localparam logic [YEAR_W-1:0] DIV25_LIM = 16'd2621;

    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_SUB  = 2'd1,
        OP_CMP  = 2'd2,
        OP_DIST = 2'd3
    } op_t;

    localparam logic signed [ORDER_W-1:0] ORD_LESS  = -2'sd1;
    localparam logic signed [ORDER_W-1:0] ORD_EQUAL = 2'sd0;
    localparam logic signed [ORDER_W-1:0] ORD_MORE  = 2'sd1;

    typedef struct packed {
        logic load;
        logic clamp_a;
        logic clamp_b;
        logic step_fwd;
        logic step_bwd;
        logic cnt_dec;
        logic cnt_inc;
        logic set_lim;
        logic capture;
        op_t  op;
    } gdsu_cmd_t;

    typedef struct packed {
        logic cnt_zero;
        logic steps_max;
        logic at_top;
        logic at_bottom;
        logic dates_eq;
        logic a_less;
    } gdsu_stat_t;

    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [YEAR_W-1:0] prod;
        logic              div25;
        prod  = y * INV25;
        div25 = (prod <= DIV25_LIM);
        return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
    endfunction

    function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] dim;
        unique case (m)
            MON_FEB:                            dim = leap ? DAY_29 : DAY_28;
            MON_APR, MON_JUN, MON_SEP, MON_NOV: dim = DAY_30;
            default:                            dim = DAY_31;
        endcase
        return dim;
    endfunction

endpackage

`default_nettype wire

@@ rtl/gregorian_date_step_unit_top.sv @@
// ----------------------------------------------------------------------------
// gregorian_date_step_unit_top
// gregorian date add, subtract, compare and day distance by day stepping
// ----------------------------------------------------------------------------
// One transaction carries two dates, a day count and an operation, and gives
// one result transaction. Each date is first clamped into range (month to
// 1..12, year to 1..YEAR_MAX, day to the length of that month). Add and
// subtract then walk the first date one day per clock; distance walks the
// first date toward the second one day per clock and counts the steps;
// compare needs no walk. The number of day steps is min(day_count,
// MAX_STEPS) for add and subtract (fewer if the walk stops at a year
// limit), the day distance capped at MAX_STEPS for distance, and 0 for
// compare. The walk is done by the single day-step unit in the datapath,
// which advances the working date by one day per clock. in_stall is low
// only while the unit is idle; a finished result sits in the output
// register until taken, and the next transaction may be accepted while it
// waits. limit_hit flags a walk cut short at 31 December of YEAR_MAX, at
// 1 January of year 1, at the step limit or by saturation of distance at
// 65535.
// ----------------------------------------------------------------------------
`default_nettype none

module gregorian_date_step_unit_top
    import gdsu_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEF,   // 1 .. 4194303
    parameter int YEAR_MAX  = YEAR_MAX_DEF     // 1 .. 65535
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    // input transaction
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [1:0]            operation,
    input  wire logic [DAY_W-1:0]      day_a,
    input  wire logic [MON_W-1:0]      month_a,
    input  wire logic [YEAR_IN_W-1:0]  year_a,
    input  wire logic [DAY_W-1:0]      day_b,
    input  wire logic [MON_W-1:0]      month_b,
    input  wire logic [YEAR_IN_W-1:0]  year_b,
    input  wire logic [COUNT_W-1:0]    day_count,

    // result transaction
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [DAY_W-1:0]           day_out,
    output logic [MON_W-1:0]           month_out,
    output logic [YEAR_IN_W-1:0]       year_out,
    output logic signed [ORDER_W-1:0]  order,
    output logic [COUNT_W-1:0]         distance,
    output logic                       limit_hit
);

    // commands from the sequencer, status back from the datapath
    gdsu_cmd_t  cmd;
    gdsu_stat_t stat;

    gdsu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    // date registers, leap-year and month-length logic, step counter and
    // the output register that holds the result until it is taken
    gdsu_datapath #(
        .MAX_STEPS (MAX_STEPS),
        .YEAR_MAX  (YEAR_MAX)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .day_a     (day_a),
        .month_a   (month_a),
        .year_a    (year_a),
        .day_b     (day_b),
        .month_b   (month_b),
        .year_b    (year_b),
        .day_count (day_count),
        .day_out   (day_out),
        .month_out (month_out),
        .year_out  (year_out),
        .order     (order),
        .distance  (distance),
        .limit_hit (limit_hit)
    );

endmodule

`default_nettype wire

@@ rtl/gdsu_datapath.sv @@
// ----------------------------------------------------------------------------
// gdsu_datapath
// date registers, clamp and day step logic, step counter and result register
// ----------------------------------------------------------------------------
`default_nettype none

module gdsu_datapath
    import gdsu_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEF,
    parameter int YEAR_MAX  = YEAR_MAX_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire gdsu_cmd_t                    cmd,
    output gdsu_stat_t                        stat,
    input  wire logic [DAY_W-1:0]             day_a,
    input  wire logic [MON_W-1:0]             month_a,
    input  wire logic [YEAR_IN_W-1:0]         year_a,
    input  wire logic [DAY_W-1:0]             day_b,
    input  wire logic [MON_W-1:0]             month_b,
    input  wire logic [YEAR_IN_W-1:0]         year_b,
    input  wire logic [COUNT_W-1:0]           day_count,
    output logic      [DAY_W-1:0]             day_out,
    output logic      [MON_W-1:0]             month_out,
    output logic      [YEAR_IN_W-1:0]         year_out,
    output logic signed [ORDER_W-1:0]         order,
    output logic      [COUNT_W-1:0]           distance,
    output logic                              limit_hit
);

    localparam int STEP_W = $clog2(MAX_STEPS + 1);
    localparam int CMP_W  = (STEP_W > COUNT_W) ? STEP_W : COUNT_W;
    localparam logic [YEAR_W-1:0] YEAR_TOP  = YEAR_W'(YEAR_MAX);
    localparam logic [YEAR_W-1:0] YEAR_ONE  = YEAR_W'(1);
    localparam logic [STEP_W-1:0] STEP_TOP  = STEP_W'(MAX_STEPS);
    localparam logic [CMP_W-1:0]  STEP_CMP  = CMP_W'(MAX_STEPS);
    localparam logic [CMP_W-1:0]  SAT_CMP   = CMP_W'(DIST_SAT);

    function automatic logic [YEAR_W-1:0] clamp_year(input logic [YEAR_IN_W-1:0] y);
        logic [YEAR_W-1:0] ye;
        ye = YEAR_W'(y);
        if (ye == '0)
            ye = YEAR_ONE;
        else if (ye > YEAR_TOP)
            ye = YEAR_TOP;
        return ye;
    endfunction

    function automatic logic [MON_W-1:0] clamp_month(input logic [MON_W-1:0] m);
        logic [MON_W-1:0] mc;
        mc = m;
        if (m == '0)
            mc = MON_JAN;
        else if (m > MON_DEC)
            mc = MON_DEC;
        return mc;
    endfunction

    function automatic logic [DAY_W-1:0] clamp_day(input logic [DAY_W-1:0] d,
                                                   input logic [DAY_W-1:0] dim);
        logic [DAY_W-1:0] dc;
        dc = d;
        if (d == '0)
            dc = DAY_FIRST;
        else if (d > dim)
            dc = dim;
        return dc;
    endfunction

    // working date (first date) and target date (second date)
    logic [DAY_W-1:0]   d_reg,  d_next;
    logic [MON_W-1:0]   m_reg,  m_next;
    logic [YEAR_W-1:0]  y_reg,  y_next;
    logic [DAY_W-1:0]   db_reg, db_next;
    logic [MON_W-1:0]   mb_reg, mb_next;
    logic [YEAR_W-1:0]  yb_reg, yb_next;
    logic [STEP_W-1:0]  cnt_reg, cnt_next;
    logic               lim_reg, lim_next;

    logic [DAY_W-1:0]   day_out_reg,   day_out_next;
    logic [MON_W-1:0]   month_out_reg, month_out_next;
    logic [YEAR_IN_W-1:0] year_out_reg, year_out_next;
    logic signed [ORDER_W-1:0] order_reg, order_next;
    logic [COUNT_W-1:0] distance_reg,  distance_next;
    logic               limit_reg,     limit_next;

    logic               leap;
    logic [YEAR_W-1:0]  leap_year;
    logic [MON_W-1:0]   dim_month;
    logic [DAY_W-1:0]   dim;
    logic [DAY_W-1:0]   dim_prev;
    logic [MON_W-1:0]   m_dec;
    logic               count_over;
    logic               dist_sat;
    logic               a_less;
    logic               dates_eq;

    // one leap unit, pointed at the second year while it is clamped
    assign leap_year = cmd.clamp_b ? yb_reg : y_reg;
    assign dim_month = cmd.clamp_b ? mb_reg : m_reg;
    assign leap      = is_leap(leap_year);
    assign dim       = month_days(dim_month, leap);
    assign m_dec     = m_reg - MON_W'(1);
    assign dim_prev  = month_days(m_dec, leap);

    assign count_over = CMP_W'(day_count) > STEP_CMP;
    assign dist_sat   = CMP_W'(cnt_reg) > SAT_CMP;
    assign a_less     = {y_reg, m_reg, d_reg} < {yb_reg, mb_reg, db_reg};
    assign dates_eq   = {y_reg, m_reg, d_reg} == {yb_reg, mb_reg, db_reg};

    always_comb
    begin
        stat.cnt_zero  = (cnt_reg == '0);
        stat.steps_max = (cnt_reg >= STEP_TOP);
        stat.at_top    = (d_reg == dim) && (m_reg == MON_DEC) && (y_reg >= YEAR_TOP);
        stat.at_bottom = (d_reg == DAY_FIRST) && (m_reg == MON_JAN) && (y_reg <= YEAR_ONE);
        stat.dates_eq  = dates_eq;
        stat.a_less    = a_less;
    end

    always_comb
    begin
        d_next   = d_reg;
        m_next   = m_reg;
        y_next   = y_reg;
        db_next  = db_reg;
        mb_next  = mb_reg;
        yb_next  = yb_reg;
        cnt_next = cnt_reg;
        lim_next = lim_reg;

        if (cmd.load)
        begin
            d_next  = day_a;
            m_next  = clamp_month(month_a);
            y_next  = clamp_year(year_a);
            db_next = day_b;
            mb_next = clamp_month(month_b);
            yb_next = clamp_year(year_b);
            if (cmd.op == OP_ADD || cmd.op == OP_SUB)
            begin
                cnt_next = count_over ? STEP_TOP : STEP_W'(day_count);
                lim_next = count_over;
            end
            else
            begin
                cnt_next = '0;
                lim_next = 1'b0;
            end
        end
        if (cmd.clamp_a)
            d_next = clamp_day(d_reg, dim);
        if (cmd.clamp_b)
            db_next = clamp_day(db_reg, dim);
        if (cmd.step_fwd)
        begin
            if (d_reg < dim)
                d_next = d_reg + DAY_W'(1);
            else if (m_reg < MON_DEC)
            begin
                m_next = m_reg + MON_W'(1);
                d_next = DAY_FIRST;
            end
            else
            begin
                y_next = y_reg + YEAR_W'(1);
                m_next = MON_JAN;
                d_next = DAY_FIRST;
            end
        end
        if (cmd.step_bwd)
        begin
            if (d_reg > DAY_FIRST)
                d_next = d_reg - DAY_W'(1);
            else if (m_reg > MON_JAN)
            begin
                m_next = m_dec;
                d_next = dim_prev;
            end
            else
            begin
                y_next = y_reg - YEAR_W'(1);
                m_next = MON_DEC;
                d_next = DAY_31;
            end
        end
        if (cmd.cnt_dec)
            cnt_next = cnt_reg - STEP_W'(1);
        if (cmd.cnt_inc)
            cnt_next = cnt_reg + STEP_W'(1);
        if (cmd.set_lim)
            lim_next = 1'b1;
    end

    // result fields, zero where the operation does not define them
    always_comb
    begin
        day_out_next   = day_out_reg;
        month_out_next = month_out_reg;
        year_out_next  = year_out_reg;
        order_next     = order_reg;
        distance_next  = distance_reg;
        limit_next     = limit_reg;
        if (cmd.capture)
        begin
            day_out_next   = '0;
            month_out_next = '0;
            year_out_next  = '0;
            order_next     = ORD_EQUAL;
            distance_next  = '0;
            limit_next     = lim_reg;
            unique case (cmd.op)
                OP_ADD, OP_SUB:
                begin
                    day_out_next   = d_reg;
                    month_out_next = m_reg;
                    year_out_next  = y_reg[YEAR_IN_W-1:0];
                end
                OP_CMP:
                begin
                    limit_next = 1'b0;
                    if (dates_eq)
                        order_next = ORD_EQUAL;
                    else if (a_less)
                        order_next = ORD_LESS;
                    else
                        order_next = ORD_MORE;
                end
                OP_DIST:
                begin
                    distance_next = dist_sat ? DIST_SAT : COUNT_W'(cnt_reg);
                    limit_next    = lim_reg || dist_sat;
                end
                default:
                begin
                    limit_next = lim_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            lim_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            lim_reg <= lim_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg         <= d_next;
        m_reg         <= m_next;
        y_reg         <= y_next;
        db_reg        <= db_next;
        mb_reg        <= mb_next;
        yb_reg        <= yb_next;
        day_out_reg   <= day_out_next;
        month_out_reg <= month_out_next;
        year_out_reg  <= year_out_next;
        order_reg     <= order_next;
        distance_reg  <= distance_next;
        limit_reg     <= limit_next;
    end

    assign day_out   = day_out_reg;
    assign month_out = month_out_reg;
    assign year_out  = year_out_reg;
    assign order     = order_reg;
    assign distance  = distance_reg;
    assign limit_hit = limit_reg;

`ifndef SYNTHESIS
    // a day step always moves the working date
    a_step_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step_fwd || cmd.step_bwd) |=>
            !(d_reg == $past(d_reg) && m_reg == $past(m_reg) && y_reg == $past(y_reg)))
        else $error("day step left the working date unchanged");

    // the down counter never wraps below zero
    a_cnt_no_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_dec |-> cnt_reg != '0)
        else $error("step counter decremented at zero");

    // the distance counter never runs past the step limit
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_inc |=> cnt_reg <= STEP_TOP)
        else $error("distance counter passed the step limit");
`endif

endmodule

`default_nettype wire

@@ rtl/gdsu_ctrl.sv @@
// ----------------------------------------------------------------------------
// gdsu_ctrl
// sequencer for load, clamp, day walk and result handoff
// ----------------------------------------------------------------------------
`default_nettype none

module gdsu_ctrl
    import gdsu_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [1:0]       operation,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output gdsu_cmd_t             cmd,
    input  wire gdsu_stat_t       stat
);

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_CLAMP_A = 5'b00010,
        ST_CLAMP_B = 5'b00100,
        ST_WALK    = 5'b01000,
        ST_DONE    = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    op_t    op_reg,    op_next;
    logic   out_valid_reg, out_valid_next;
    logic   in_take;
    logic   out_take;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_take = out_valid_reg && !out_stall;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd        = '0;
        cmd.op     = op_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    cmd.load   = 1'b1;
                    cmd.op     = op_t'(operation);
                    op_next    = op_t'(operation);
                    state_next = ST_CLAMP_A;
                end
            end
            ST_CLAMP_A:
            begin
                cmd.clamp_a = 1'b1;
                state_next  = ST_CLAMP_B;
            end
            ST_CLAMP_B:
            begin
                cmd.clamp_b = 1'b1;
                state_next  = ST_WALK;
            end
            ST_WALK:
            begin
                unique case (op_reg)
                    OP_ADD:
                    begin
                        if (stat.cnt_zero)
                            state_next = ST_DONE;
                        else if (stat.at_top)
                        begin
                            cmd.set_lim = 1'b1;
                            state_next  = ST_DONE;
                        end
                        else
                        begin
                            cmd.step_fwd = 1'b1;
                            cmd.cnt_dec  = 1'b1;
                        end
                    end
                    OP_SUB:
                    begin
                        if (stat.cnt_zero)
                            state_next = ST_DONE;
                        else if (stat.at_bottom)
                        begin
                            cmd.set_lim = 1'b1;
                            state_next  = ST_DONE;
                        end
                        else
                        begin
                            cmd.step_bwd = 1'b1;
                            cmd.cnt_dec  = 1'b1;
                        end
                    end
                    OP_CMP:
                    begin
                        state_next = ST_DONE;
                    end
                    OP_DIST:
                    begin
                        if (stat.dates_eq)
                            state_next = ST_DONE;
                        else if (stat.steps_max)
                        begin
                            cmd.set_lim = 1'b1;
                            state_next  = ST_DONE;
                        end
                        else
                        begin
                            cmd.step_fwd = stat.a_less;
                            cmd.step_bwd = !stat.a_less;
                            cmd.cnt_inc  = 1'b1;
                        end
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.capture)
            out_valid_next = 1'b1;
        else if (out_take)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_ADD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_one_direction: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.step_fwd && cmd.step_bwd))
        else $error("forward and backward step in the same cycle");

    a_accept_clamps: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> state_reg == ST_CLAMP_A)
        else $error("accepted transaction did not start clamping");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result presented outside the handoff state");

    a_compare_one_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK && op_reg == OP_CMP) |=> state_reg == ST_DONE)
        else $error("compare stayed in the walk state");
`endif

endmodule

`default_nettype wire

@@ verif/date_step_checker.sv @@
// ----------------------------------------------------------------------------
// date_step_checker
// watches both channels of the date step unit, works out the expected result
// of every accepted transaction and compares it field by field
// ----------------------------------------------------------------------------

module date_step_checker
    import gdsu_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic [1:0]                 operation,
    input  logic [DAY_W-1:0]           day_a,
    input  logic [MON_W-1:0]           month_a,
    input  logic [YEAR_IN_W-1:0]       year_a,
    input  logic [DAY_W-1:0]           day_b,
    input  logic [MON_W-1:0]           month_b,
    input  logic [YEAR_IN_W-1:0]       year_b,
    input  logic [COUNT_W-1:0]         day_count,

    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic [DAY_W-1:0]           day_out,
    input  logic [MON_W-1:0]           month_out,
    input  logic [YEAR_IN_W-1:0]       year_out,
    input  logic signed [ORDER_W-1:0]  order,
    input  logic [COUNT_W-1:0]         distance,
    input  logic                       limit_hit,

    output int                         fail_count,
    output int                         pending,
    output int                         results_checked,
    output int                         limit_results
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STEP_LIMIT = MAX_STEPS_DEF;
    localparam int unsigned LAST_YEAR  = YEAR_MAX_DEF;

    typedef struct {
        int unsigned d;
        int unsigned m;
        int unsigned y;
    } cal_t;

    typedef struct {
        logic [DAY_W-1:0]          day;
        logic [MON_W-1:0]          month;
        logic [YEAR_IN_W-1:0]      year;
        logic signed [ORDER_W-1:0] ord;
        logic [COUNT_W-1:0]        span;
        logic                      lim;
    } date_result_t;

    date_result_t expected_q[$];
    date_result_t want;
    int           fails;
    int           checked;
    int           limits;
    bit           bad;

    function automatic bit leap_year(int unsigned y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic int unsigned days_of(int unsigned m, int unsigned y);
        if (m == MON_FEB)
            return leap_year(y) ? DAY_29 : DAY_28;
        if (m == MON_APR || m == MON_JUN || m == MON_SEP || m == MON_NOV)
            return DAY_30;
        return DAY_31;
    endfunction

    function automatic cal_t clamp_in(int unsigned d, int unsigned m, int unsigned y);
        cal_t        c;
        int unsigned dim;
        c.m = (m < MON_JAN) ? MON_JAN : ((m > MON_DEC) ? MON_DEC : m);
        c.y = (y < 1) ? 1 : ((y > LAST_YEAR) ? LAST_YEAR : y);
        dim = days_of(c.m, c.y);
        c.d = (d < DAY_FIRST) ? DAY_FIRST : ((d > dim) ? dim : d);
        return c;
    endfunction

    function automatic int cmp_cal(cal_t a, cal_t b);
        if (a.y != b.y) return (a.y > b.y) ? 1 : -1;
        if (a.m != b.m) return (a.m > b.m) ? 1 : -1;
        if (a.d != b.d) return (a.d > b.d) ? 1 : -1;
        return 0;
    endfunction

    // one day forward, refused at the last day of the last year
    function automatic bit day_fwd(inout cal_t p);
        if (p.d < days_of(p.m, p.y)) begin
            p.d++;
            return 1'b1;
        end
        if (p.m < MON_DEC) begin
            p.m++;
            p.d = DAY_FIRST;
            return 1'b1;
        end
        if (p.y >= LAST_YEAR)
            return 1'b0;
        p.y++;
        p.m = MON_JAN;
        p.d = DAY_FIRST;
        return 1'b1;
    endfunction

    // one day back, refused at 1 january of year 1
    function automatic bit day_bwd(inout cal_t p);
        if (p.d > DAY_FIRST) begin
            p.d--;
            return 1'b1;
        end
        if (p.m > MON_JAN) begin
            p.m--;
            p.d = days_of(p.m, p.y);
            return 1'b1;
        end
        if (p.y <= 1)
            return 1'b0;
        p.y--;
        p.m = MON_DEC;
        p.d = DAY_31;
        return 1'b1;
    endfunction

    function automatic date_result_t date_outcome(op_t op, cal_t a, cal_t b,
                                                  int unsigned cnt);
        date_result_t r;
        int unsigned  n;
        int unsigned  i;
        int unsigned  steps;
        int           c;
        bit           ok;
        r.day   = '0;
        r.month = '0;
        r.year  = '0;
        r.ord   = ORD_EQUAL;
        r.span  = '0;
        r.lim   = 1'b0;
        case (op)
            OP_ADD, OP_SUB:
            begin
                n = cnt;
                if (n > STEP_LIMIT)
                begin
                    n     = STEP_LIMIT;
                    r.lim = 1'b1;
                end
                for (i = 0; i < n; i++)
                begin
                    if (op == OP_ADD)
                        ok = day_fwd(a);
                    else
                        ok = day_bwd(a);
                    if (!ok)
                    begin
                        r.lim = 1'b1;
                        break;
                    end
                end
                r.day   = DAY_W'(a.d);
                r.month = MON_W'(a.m);
                r.year  = YEAR_IN_W'(a.y);
            end
            OP_CMP:
            begin
                c     = cmp_cal(a, b);
                r.ord = (c < 0) ? ORD_LESS : ((c > 0) ? ORD_MORE : ORD_EQUAL);
            end
            default:
            begin
                steps = 0;
                c     = cmp_cal(a, b);
                while (c != 0)
                begin
                    if (steps >= STEP_LIMIT)
                    begin
                        r.lim = 1'b1;
                        break;
                    end
                    if (c < 0)
                        void'(day_fwd(a));
                    else
                        void'(day_bwd(a));
                    steps++;
                    c = cmp_cal(a, b);
                end
                if (steps > DIST_SAT)
                begin
                    steps = DIST_SAT;
                    r.lim = 1'b1;
                end
                r.span = COUNT_W'(steps);
            end
        endcase
        return r;
    endfunction

    function automatic bit field_ok(string name, logic signed [31:0] exp,
                                    logic signed [31:0] got);
        if (got !== exp)
        begin
            $error("%s: expected %0d, got %0d", name, exp, got);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    initial
    begin
        fails   = 0;
        checked = 0;
        limits  = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                expected_q.push_back(date_outcome(op_t'(operation),
                                                  clamp_in(day_a, month_a, year_a),
                                                  clamp_in(day_b, month_b, year_b),
                                                  day_count));
            if (out_valid && !out_stall)
            begin
                checked++;
                if (limit_hit === 1'b1)
                    limits++;
                if (expected_q.size() == 0)
                begin
                    $error("result transaction with no transaction waiting for it");
                    fails++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    bad  = 1'b0;
                    bad |= !field_ok("day_out", want.day, day_out);
                    bad |= !field_ok("month_out", want.month, month_out);
                    bad |= !field_ok("year_out", want.year, year_out);
                    bad |= !field_ok("order", want.ord, order);
                    bad |= !field_ok("distance", want.span, distance);
                    bad |= !field_ok("limit_hit", want.lim, limit_hit);
                    if (bad)
                        fails++;
                end
            end
        end
    end

    assign fail_count      = fails;
    assign pending         = expected_q.size();
    assign results_checked = checked;
    assign limit_results   = limits;

endmodule

@@ verif/gregorian_date_step_unit_top_tb.sv @@
// ----------------------------------------------------------------------------
// gregorian_date_step_unit_top_tb
// drives date transactions into the date step unit with random idling on both
// sides and lets the checker judge every result
// ----------------------------------------------------------------------------

module gregorian_date_step_unit_top_tb
    import gdsu_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // number of random transactions after the directed ones
    localparam int RANDOM_JOBS = 115;
    // the receiver holds off once, after this many results, for this long
    localparam int HOLD_AT     = 30;
    localparam int HOLD_CYCLES = 2000;
    // cycles to watch for stray results once nothing is expected
    localparam int TAIL_CYCLES = 50;

    // one input transaction as the sender sees it
    typedef struct {
        op_t                  op;
        logic [DAY_W-1:0]     da;
        logic [MON_W-1:0]     ma;
        logic [YEAR_IN_W-1:0] ya;
        logic [DAY_W-1:0]     db;
        logic [MON_W-1:0]     mb;
        logic [YEAR_IN_W-1:0] yb;
        logic [COUNT_W-1:0]   cnt;
    } date_job_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic [1:0]                operation;
    logic [DAY_W-1:0]          day_a;
    logic [MON_W-1:0]          month_a;
    logic [YEAR_IN_W-1:0]      year_a;
    logic [DAY_W-1:0]          day_b;
    logic [MON_W-1:0]          month_b;
    logic [YEAR_IN_W-1:0]      year_b;
    logic [COUNT_W-1:0]        day_count;
    logic                      out_valid;
    logic                      out_stall;
    logic [DAY_W-1:0]          day_out;
    logic [MON_W-1:0]          month_out;
    logic [YEAR_IN_W-1:0]      year_out;
    logic signed [ORDER_W-1:0] order;
    logic [COUNT_W-1:0]        distance;
    logic                      limit_hit;

    int fail_count;
    int pending;
    int results_checked;
    int limit_results;

    date_job_t directed_q[$];
    int        jobs_sent;
    int        op_mix[4];
    int        idx;

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    gregorian_date_step_unit_top uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .day_a     (day_a),
        .month_a   (month_a),
        .year_a    (year_a),
        .day_b     (day_b),
        .month_b   (month_b),
        .year_b    (year_b),
        .day_count (day_count),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .day_out   (day_out),
        .month_out (month_out),
        .year_out  (year_out),
        .order     (order),
        .distance  (distance),
        .limit_hit (limit_hit)
    );

    // prediction and comparison live beside the block
    date_step_checker u_check
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .operation       (operation),
        .day_a           (day_a),
        .month_a         (month_a),
        .year_a          (year_a),
        .day_b           (day_b),
        .month_b         (month_b),
        .year_b          (year_b),
        .day_count       (day_count),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .day_out         (day_out),
        .month_out       (month_out),
        .year_out        (year_out),
        .order           (order),
        .distance        (distance),
        .limit_hit       (limit_hit),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked),
        .limit_results   (limit_results)
    );

    // idle length: mostly none or short, now and then long
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(16, 80);
    endfunction

    function automatic date_job_t job(op_t op, int da, int ma, int ya,
                                      int db, int mb, int yb, int cnt);
        date_job_t j;
        j.op  = op;
        j.da  = DAY_W'(da);
        j.ma  = MON_W'(ma);
        j.ya  = YEAR_IN_W'(ya);
        j.db  = DAY_W'(db);
        j.mb  = MON_W'(mb);
        j.yb  = YEAR_IN_W'(yb);
        j.cnt = COUNT_W'(cnt);
        return j;
    endfunction

    // years lean toward both ends of the calendar so the bound flags fire
    function automatic logic [YEAR_IN_W-1:0] pick_year();
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r == 0) return YEAR_IN_W'($urandom_range(1, 3));
        if (r == 1) return YEAR_IN_W'($urandom_range(YEAR_MAX_DEF - 2, YEAR_MAX_DEF));
        return YEAR_IN_W'($urandom_range(1, YEAR_MAX_DEF));
    endfunction

    function automatic date_job_t random_job();
        date_job_t j;
        bit        raw;
        bit        far;
        int        yb;
        j.op = op_t'($urandom_range(0, 3));
        // a share of dates is plain bit noise, which the block clamps
        raw = ($urandom_range(0, 6) == 0);
        far = ($urandom_range(0, 39) == 0);
        if (raw)
        begin
            j.da = DAY_W'($urandom);
            j.ma = MON_W'($urandom);
            j.ya = YEAR_IN_W'($urandom);
            j.db = DAY_W'($urandom);
            j.mb = MON_W'($urandom);
        end
        else
        begin
            j.da = DAY_W'($urandom_range(1, 31));
            j.ma = MON_W'($urandom_range(MON_JAN, MON_DEC));
            j.ya = pick_year();
            j.db = DAY_W'($urandom_range(1, 31));
            j.mb = MON_W'($urandom_range(MON_JAN, MON_DEC));
        end
        // distance walks are kept short except for the odd far pair
        if (j.op == OP_DIST && !far)
        begin
            yb = int'(j.ya) + int'($urandom_range(0, 2)) - 1;
            if (yb < 0)
                yb = 0;
            if (yb > 2**YEAR_IN_W - 1)
                yb = 2**YEAR_IN_W - 1;
            j.yb = YEAR_IN_W'(yb);
        end
        else if (raw)
            j.yb = YEAR_IN_W'($urandom);
        else
            j.yb = pick_year();
        // identical dates for some compares and distances
        if ((j.op == OP_CMP && $urandom_range(0, 3) == 0) ||
            (j.op == OP_DIST && $urandom_range(0, 7) == 0))
        begin
            j.db = j.da;
            j.mb = j.ma;
            j.yb = j.ya;
        end
        // long walks are rare; the count is noise for compare and distance
        if (j.op == OP_ADD || j.op == OP_SUB)
        begin
            if ($urandom_range(0, 39) == 0)
                j.cnt = COUNT_W'($urandom);
            else if ($urandom_range(0, 4) == 0)
                j.cnt = COUNT_W'($urandom_range(0, 3000));
            else
                j.cnt = COUNT_W'($urandom_range(0, 120));
        end
        else
            j.cnt = COUNT_W'($urandom);
        return j;
    endfunction

    // offer one transaction and return at the edge where it is taken
    task automatic send_job(date_job_t j, bit no_gap);
        int unsigned gap;
        gap = no_gap ? 0 : idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= j.op;
        day_a     <= j.da;
        month_a   <= j.ma;
        year_a    <= j.ya;
        day_b     <= j.db;
        month_b   <= j.mb;
        year_b    <= j.yb;
        day_count <= j.cnt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        jobs_sent++;
        op_mix[j.op]++;
    endtask

    // receiver: random stall runs, stretches with no stall, and one long
    // hold-off so the block fills up and stalls its input
    initial
    begin
        int unsigned stall_left;
        int unsigned open_left;
        bit          held;
        stall_left = 0;
        open_left  = 0;
        held       = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held && results_checked >= HOLD_AT)
            begin
                held       = 1'b1;
                stall_left = HOLD_CYCLES;
                open_left  = 1;
            end
            else if (stall_left == 0 && open_left == 0)
            begin
                stall_left = idle_len();
                open_left  = ($urandom_range(0, 15) == 0) ? 150 : $urandom_range(1, 8);
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                open_left--;
            end
        end
    end

    // watchdog, sized well past the slowest legal run
    initial
    begin
        #250_000_000;
        $error("timeout with %0d results still expected", pending);
        $display("status: fail");
        $finish;
    end

    // stimulus and verdict
    initial
    begin
        jobs_sent = 0;
        foreach (op_mix[k])
            op_mix[k] = 0;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        operation <= OP_ADD;
        day_a     <= '0;
        month_a   <= '0;
        year_a    <= '0;
        day_b     <= '0;
        month_b   <= '0;
        year_b    <= '0;
        day_count <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // plain add of nothing, month end, year end
        directed_q.push_back(job(OP_ADD, 15, 6, 2023, 1, 1, 1, 0));
        directed_q.push_back(job(OP_ADD, 31, 1, 2023, 1, 1, 1, 1));
        directed_q.push_back(job(OP_ADD, 31, 12, 1999, 1, 1, 1, 1));
        // leap day rules: ordinary leap, century non-leap, 400-year leap
        directed_q.push_back(job(OP_ADD, 28, 2, 2024, 1, 1, 1, 1));
        directed_q.push_back(job(OP_ADD, 28, 2, 2100, 1, 1, 1, 1));
        directed_q.push_back(job(OP_ADD, 28, 2, 2000, 1, 1, 1, 2));
        // stepping back over month and year starts
        directed_q.push_back(job(OP_SUB, 1, 3, 2000, 1, 1, 1, 1));
        directed_q.push_back(job(OP_SUB, 1, 1, 2000, 1, 1, 1, 1));
        directed_q.push_back(job(OP_SUB, 1, 5, 2023, 1, 1, 1, 1));
        // upper year bound: landing exactly on it, then running into it
        directed_q.push_back(job(OP_ADD, 31, 12, 9998, 1, 1, 1, 365));
        directed_q.push_back(job(OP_ADD, 31, 12, 9999, 1, 1, 1, 1));
        directed_q.push_back(job(OP_ADD, 20, 12, 9999, 1, 1, 1, 100));
        // lower year bound
        directed_q.push_back(job(OP_SUB, 1, 1, 1, 1, 1, 1, 1));
        directed_q.push_back(job(OP_SUB, 5, 1, 1, 1, 1, 1, 10));
        // largest day count
        directed_q.push_back(job(OP_ADD, 1, 1, 2000, 1, 1, 1, 65535));
        // clamping of out-of-range day, month and year
        directed_q.push_back(job(OP_ADD, 0, 0, 0, 0, 0, 0, 0));
        directed_q.push_back(job(OP_ADD, 31, 15, 16383, 31, 15, 16383, 0));
        directed_q.push_back(job(OP_SUB, 30, 2, 1900, 1, 1, 1, 0));
        // compare: earlier, equal once clamped, later
        directed_q.push_back(job(OP_CMP, 10, 5, 2020, 11, 5, 2020, 0));
        directed_q.push_back(job(OP_CMP, 31, 2, 2001, 28, 2, 2001, 0));
        directed_q.push_back(job(OP_CMP, 1, 1, 2021, 31, 12, 2020, 65535));
        // distance: equal, forward, backward, and one cut off at the step limit
        directed_q.push_back(job(OP_DIST, 7, 7, 2007, 7, 7, 2007, 0));
        directed_q.push_back(job(OP_DIST, 20, 2, 2024, 10, 3, 2024, 0));
        directed_q.push_back(job(OP_DIST, 10, 3, 2024, 20, 2, 2024, 0));
        directed_q.push_back(job(OP_DIST, 1, 1, 1, 31, 12, 9999, 0));

        foreach (directed_q[k])
            send_job(directed_q[k], 1'b0);

        // random part, with a stretch in the middle where the sender never idles
        for (idx = 0; idx < RANDOM_JOBS; idx++)
            send_job(random_job(), idx >= 60 && idx < 90);
        in_valid <= 1'b0;

        // drain: let the checker record the last push before waiting on pending
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d transactions: %0d add, %0d subtract, %0d compare, %0d distance",
                 jobs_sent, op_mix[OP_ADD], op_mix[OP_SUB], op_mix[OP_CMP], op_mix[OP_DIST]);
        $display("checked %0d results, %0d of them with limit_hit set",
                 results_checked, limit_results);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
